FILE: hdl/fsm_pkg.sv
// Package: shared types and constants for the fraction sum and max block.
package fsm_pkg;
  localparam int NumW  = 16;
  localparam int SumW  = 48;
  localparam int AccW  = 32;
  localparam int DenW  = 31;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic divn_start;
    logic divd_start;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic zero_sum;
    logic gcd_done;
    logic div_done;
    logic busy;
  } sts_t;
endpackage

FILE: hdl/fsm_if.sv
// Interfaces: input and result channels.
interface fsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] num_in;
  logic signed [15:0] den_in;
  logic               first;
  modport source (output valid, num_in, den_in, first, input ready);
  modport sink (input valid, num_in, den_in, first, output ready);
endinterface

interface fsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum_num;
  logic        [30:0] sum_den;
  logic signed [15:0] max_num;
  logic signed [15:0] max_den;
  logic               bad_item;
  logic               overflow;
  modport source (output valid, sum_num, sum_den, max_num, max_den, bad_item, overflow,
                  input ready);
  modport sink (input valid, sum_num, sum_den, max_num, max_den, bad_item, overflow,
                output ready);
endinterface

FILE: hdl/fsm_ctrl.sv
// Controller: multiply, then GCD and two divisions unless bad or zero sum.
module fsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fsm_pkg::sts_t sts,
  output fsm_pkg::cmd_t cmd
);
  import fsm_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL: begin
        if (sts.bad || sts.zero_sum) state_nxt = ST_DONE;
        else                         state_nxt = ST_GCD;
      end
      ST_GCD:  if (sts.gcd_done) state_nxt = ST_DIVN;
      ST_DIVN: if (sts.div_done) state_nxt = ST_DIVD;
      ST_DIVD: if (sts.div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.commit = sts.bad || sts.zero_sum;
      end
      ST_GCD: begin
        cmd.gcd_step = !sts.gcd_done && !sts.busy;
        cmd.div_step = sts.busy && !sts.div_done;
        cmd.divn_start = sts.gcd_done;
      end
      ST_DIVN: begin
        cmd.div_step = !sts.div_done;
        cmd.divd_start = sts.div_done;
      end
      ST_DIVD: begin
        cmd.div_step = !sts.div_done;
        cmd.commit = sts.div_done;
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: hdl/fsm_dp.sv
// Datapath: cross-multiply sum, modulo GCD by shift-subtract division, reduce, running max.
module fsm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fsm_pkg::cmd_t       cmd,
  output fsm_pkg::sts_t       sts,
  input  logic signed [15:0]  num_in,
  input  logic signed [15:0]  den_in,
  input  logic                first,
  output logic signed [31:0]  sum_num,
  output logic        [30:0]  sum_den,
  output logic signed [15:0]  max_num,
  output logic signed [15:0]  max_den,
  output logic                bad_item,
  output logic                overflow
);
  import fsm_pkg::*;

  logic signed [15:0] n_r, d_r;
  logic               first_r, bad_r;
  logic signed [31:0] acc_num_r;
  logic        [30:0] acc_den_r;
  logic signed [15:0] best_num_r, best_den_r;
  logic               have_best_r, ovf_r;
  logic               neg_r;
  logic [47:0] un_r, ud_r;       // magnitudes of sum
  logic [47:0] ga_r, gb_r;       // gcd operands
  logic [47:0] rem_r, quo_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        div_busy_r;
  logic [47:0] qn_r;

  // cross-multiplication
  logic signed [31:0] an_eff;
  logic        [30:0] ad_eff;
  logic signed [47:0] p1, p2, sn, sd;
  assign an_eff = first_r ? 32'sd0 : acc_num_r;
  assign ad_eff = first_r ? 31'd1 : acc_den_r;
  assign p1 = 48'(an_eff) * 48'(d_r);
  assign p2 = 48'(n_r) * 48'(signed'({1'b0, ad_eff}));
  assign sn = p1 + p2;
  assign sd = 48'(signed'({1'b0, ad_eff})) * 48'(d_r);

  // one restoring division step
  logic [48:0] trial;
  logic [47:0] rem_sh;
  assign rem_sh = {rem_r[46:0], quo_r[47]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_r};

  // max compare
  logic signed [31:0] lhs, rhs;
  logic flip, less;
  assign lhs = 32'(best_num_r) * 32'(d_r);
  assign rhs = 32'(n_r) * 32'(best_den_r);
  assign flip = best_den_r[15] ^ d_r[15];
  assign less = flip ? (lhs > rhs) : (lhs < rhs);

  logic fits;
  assign fits = (quo_r <= 48'h7FFF_FFFF) &&
                (neg_r ? qn_r <= 48'h8000_0000 : qn_r <= 48'h7FFF_FFFF);

  assign sts.bad = bad_r;
  assign sts.zero_sum = (sn == 48'sd0);
  assign sts.gcd_done = (gb_r == 48'd0) && !div_busy_r;
  assign sts.div_done = div_busy_r && (cnt_r == 6'd0);
  assign sts.busy = div_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_num_r <= '0; acc_den_r <= 31'd1;
      best_num_r <= '0; best_den_r <= 16'sd1;
      have_best_r <= 1'b0; ovf_r <= 1'b0; bad_r <= 1'b0;
      div_busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        n_r <= num_in; d_r <= den_in; first_r <= first;
        bad_r <= (den_in == 16'sd0);
      end
      if (cmd.mul && !bad_r) begin
        neg_r <= sn[47] ^ sd[47];
        un_r <= sn[47] ? 48'(-sn) : 48'(sn);
        ud_r <= sd[47] ? 48'(-sd) : 48'(sd);
        ga_r <= sn[47] ? 48'(-sn) : 48'(sn);
        gb_r <= sd[47] ? 48'(-sd) : 48'(sd);
        if (first_r) ovf_r <= 1'b0;
        if (first_r || !have_best_r || less) begin
          best_num_r <= n_r; best_den_r <= d_r; have_best_r <= 1'b1;
        end
        if (sn == 48'sd0) begin
          acc_num_r <= '0; acc_den_r <= 31'd1;
        end
      end
      // gcd: start a mod division, then rotate on completion
      if (cmd.gcd_step) begin
        rem_r <= '0; quo_r <= ga_r; dvs_r <= gb_r;
        cnt_r <= 6'd48; div_busy_r <= 1'b1;
      end
      if (cmd.div_step && div_busy_r) begin
        if (!trial[48]) begin
          rem_r <= trial[47:0]; quo_r <= {quo_r[46:0], 1'b1};
        end else begin
          rem_r <= rem_sh; quo_r <= {quo_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      if (div_busy_r && cnt_r == 6'd0 && !cmd.divd_start && !cmd.commit
          && !cmd.div_step) begin
        ga_r <= gb_r; gb_r <= rem_r; div_busy_r <= 1'b0;
      end
      if (cmd.divn_start) begin
        rem_r <= '0; quo_r <= un_r; dvs_r <= ga_r; cnt_r <= 6'd48; div_busy_r <= 1'b1;
      end
      if (cmd.divd_start) begin
        qn_r <= quo_r;
        rem_r <= '0; quo_r <= ud_r; cnt_r <= 6'd48; div_busy_r <= 1'b1;
      end
      if (cmd.commit && !bad_r && div_busy_r) begin
        div_busy_r <= 1'b0;
        if (fits) begin
          acc_num_r <= neg_r ? 32'(-qn_r) : qn_r[31:0];
          acc_den_r <= quo_r[30:0];
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // gcd mod step: the division runs while in the gcd state
  assign sum_num = acc_num_r;
  assign sum_den = acc_den_r;
  assign max_num = best_num_r;
  assign max_den = best_den_r;
  assign bad_item = bad_r;
  assign overflow = ovf_r;
endmodule

FILE: hdl/fraction_sum_and_max_core.sv
// Top level: rational accumulator with running maximum.
// Each beat of (num_in, den_in, first) with a nonzero denominator adds the fraction to
// a reduced running sum and updates the largest fraction seen; one result beat follows
// each input beat. An item runs one multiply, then a Euclidean GCD in which every
// modulo step is a start, 48 restoring division steps and an operand swap, then leaves
// the GCD and runs two divisions that reduce numerator and denominator. A zero
// denominator or zero sum skips the GCD and the divisions. The next item can be taken
// in the cycle after the result beat is delivered.
module fraction_sum_and_max_core (
  input  logic clk,
  input  logic rst_n,
  fsm_in_if.sink    in_ch,
  fsm_out_if.source out_ch
);
  import fsm_pkg::*;
  cmd_t cmd;
  sts_t sts;

  fsm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  fsm_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .num_in(in_ch.num_in), .den_in(in_ch.den_in), .first(in_ch.first),
    .sum_num(out_ch.sum_num), .sum_den(out_ch.sum_den),
    .max_num(out_ch.max_num), .max_den(out_ch.max_den),
    .bad_item(out_ch.bad_item), .overflow(out_ch.overflow)
  );
endmodule
